/* src/uart_tx_rx_ring_buffers_assert.svh */
// assertion helpers used by the ring buffer datapath module
`ifndef UART_TX_RX_RING_BUFFERS_ASSERT_SVH
`define UART_TX_RX_RING_BUFFERS_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define UTRB_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is held
`define UTRB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/utrb_pkg.sv */
package utrb_pkg;

    // command codes carried in the input tuser
    localparam logic [1:0] CMD_RX_BYTE = 2'd0;
    localparam logic [1:0] CMD_TX_DONE = 2'd1;
    localparam logic [1:0] CMD_PUT     = 2'd2;
    localparam logic [1:0] CMD_GET     = 2'd3;

    // result bits below the receive level field
    localparam int OUT_FIXED_W = 20;

    typedef struct packed {
        logic capture;   // take the input item and update the rings
        logic load_out;  // move the step result into the output register
    } utrb_cmd_t;

    typedef struct packed {
        logic out_free;  // output register empty or being drained
    } utrb_status_t;

endpackage

/* src/utrb_ctrl.sv */
module utrb_ctrl
    import utrb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  utrb_status_t status,
    output utrb_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOAD = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // wait here until the previous result has been taken
                cmd.load_out = status.out_free;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/utrb_dp.sv */
`include "uart_tx_rx_ring_buffers_assert.svh"

module utrb_dp
    import utrb_pkg::*;
#(
    parameter int TX_DEPTH = 32,
    parameter int RX_DEPTH = 32,
    parameter int LVL_W    = $clog2(RX_DEPTH + 1),
    parameter int OUT_W    = ((OUT_FIXED_W + LVL_W + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  utrb_cmd_t        cmd,
    output utrb_status_t     status,
    input  logic [1:0]       in_cmd,
    input  logic [7:0]       in_byte,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    localparam int TXA_W = $clog2(TX_DEPTH);
    localparam int RXA_W = $clog2(RX_DEPTH);
    localparam int RXP_W = $clog2(2 * RX_DEPTH);

    // transmit ring state
    logic [7:0]       tx_ram_reg [TX_DEPTH];
    logic [TXA_W-1:0] tx_rd_ptr_reg, tx_rd_ptr_next;
    logic [TXA_W-1:0] tx_wr_ptr_reg, tx_wr_ptr_next;
    logic             tx_full_reg, tx_full_next;
    logic             tx_active_reg, tx_active_next;
    logic [7:0]       tx_rd_data_reg;

    // receive ring state, pointers count modulo twice the depth
    logic [7:0]       rx_ram_reg [RX_DEPTH];
    logic [RXP_W-1:0] rx_rd_ptr_reg, rx_rd_ptr_next;
    logic [RXP_W-1:0] rx_wr_ptr_reg, rx_wr_ptr_next;
    logic [7:0]       rx_rd_data_reg;

    // step decisions held until the result is loaded
    logic       go_reg, go_next;
    logic       acc_reg, acc_next;
    logic       tx_from_ram_reg, tx_from_ram_next;
    logic       rx_pop_reg, rx_pop_next;
    logic [7:0] byte_reg;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    logic             tx_we, tx_re, rx_we, rx_re;
    logic             tx_empty, rx_full, rx_empty;
    logic [TXA_W-1:0] tx_rd_inc, tx_wr_inc;
    logic [RXP_W-1:0] rx_rd_inc, rx_wr_inc;
    logic [RXP_W-1:0] rx_rd_fold, rx_wr_fold;
    logic [RXA_W-1:0] rx_rd_idx, rx_wr_idx;
    logic [RXP_W:0]   rx_diff;
    logic [LVL_W-1:0] rx_level;
    logic [7:0]       tx_byte_out, read_byte_out;

    assign tx_rd_inc = (tx_rd_ptr_reg == TXA_W'(TX_DEPTH - 1)) ? '0 : tx_rd_ptr_reg + 1'b1;
    assign tx_wr_inc = (tx_wr_ptr_reg == TXA_W'(TX_DEPTH - 1)) ? '0 : tx_wr_ptr_reg + 1'b1;
    assign rx_rd_inc = (rx_rd_ptr_reg == RXP_W'(2 * RX_DEPTH - 1)) ? '0 : rx_rd_ptr_reg + 1'b1;
    assign rx_wr_inc = (rx_wr_ptr_reg == RXP_W'(2 * RX_DEPTH - 1)) ? '0 : rx_wr_ptr_reg + 1'b1;

    // fold the receive counters back into the ring
    assign rx_rd_fold = (rx_rd_ptr_reg >= RXP_W'(RX_DEPTH)) ?
                        rx_rd_ptr_reg - RXP_W'(RX_DEPTH) : rx_rd_ptr_reg;
    assign rx_wr_fold = (rx_wr_ptr_reg >= RXP_W'(RX_DEPTH)) ?
                        rx_wr_ptr_reg - RXP_W'(RX_DEPTH) : rx_wr_ptr_reg;
    assign rx_rd_idx  = rx_rd_fold[RXA_W-1:0];
    assign rx_wr_idx  = rx_wr_fold[RXA_W-1:0];

    always_comb begin
        rx_diff = {1'b0, rx_wr_ptr_reg} - {1'b0, rx_rd_ptr_reg};
        if (rx_wr_ptr_reg < rx_rd_ptr_reg) begin
            rx_diff = rx_diff + (RXP_W + 1)'(2 * RX_DEPTH);
        end
    end
    assign rx_level = rx_diff[LVL_W-1:0];

    assign tx_empty = (tx_rd_ptr_reg == tx_wr_ptr_reg) && !tx_full_reg;
    assign rx_full  = (rx_level == LVL_W'(RX_DEPTH));
    assign rx_empty = (rx_level == '0);

    always_comb begin
        tx_rd_ptr_next   = tx_rd_ptr_reg;
        tx_wr_ptr_next   = tx_wr_ptr_reg;
        tx_full_next     = tx_full_reg;
        tx_active_next   = tx_active_reg;
        rx_rd_ptr_next   = rx_rd_ptr_reg;
        rx_wr_ptr_next   = rx_wr_ptr_reg;
        go_next          = go_reg;
        acc_next         = acc_reg;
        tx_from_ram_next = tx_from_ram_reg;
        rx_pop_next      = rx_pop_reg;
        tx_we            = 1'b0;
        tx_re            = 1'b0;
        rx_we            = 1'b0;
        rx_re            = 1'b0;
        if (cmd.capture) begin
            go_next          = 1'b0;
            acc_next         = 1'b0;
            tx_from_ram_next = 1'b0;
            rx_pop_next      = 1'b0;
            case (in_cmd)
                CMD_RX_BYTE: begin
                    if (!rx_full) begin
                        rx_we          = 1'b1;
                        rx_wr_ptr_next = rx_wr_inc;
                        acc_next       = 1'b1;
                    end
                end
                CMD_TX_DONE: begin
                    if (!tx_empty) begin
                        tx_re            = 1'b1;
                        go_next          = 1'b1;
                        tx_from_ram_next = 1'b1;
                        tx_rd_ptr_next   = tx_rd_inc;
                        tx_full_next     = 1'b0;
                    end else begin
                        tx_active_next = 1'b0;
                    end
                end
                CMD_PUT: begin
                    if (!tx_full_reg) begin
                        acc_next = 1'b1;
                        if (!tx_active_reg) begin
                            // idle line: hand the byte straight over
                            tx_active_next = 1'b1;
                            go_next        = 1'b1;
                        end else begin
                            tx_we          = 1'b1;
                            tx_wr_ptr_next = tx_wr_inc;
                            if (tx_wr_inc == tx_rd_ptr_reg) begin
                                tx_full_next = 1'b1;
                            end
                        end
                    end
                end
                CMD_GET: begin
                    if (!rx_empty) begin
                        rx_re          = 1'b1;
                        rx_rd_ptr_next = rx_rd_inc;
                        acc_next       = 1'b1;
                        rx_pop_next    = 1'b1;
                    end
                end
                default: begin
                    acc_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (tx_we) begin
            tx_ram_reg[tx_wr_ptr_reg] <= in_byte;
        end
        if (tx_re) begin
            tx_rd_data_reg <= tx_ram_reg[tx_rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (rx_we) begin
            rx_ram_reg[rx_wr_idx] <= in_byte;
        end
        if (rx_re) begin
            rx_rd_data_reg <= rx_ram_reg[rx_rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_rd_ptr_reg   <= '0;
            tx_wr_ptr_reg   <= '0;
            tx_full_reg     <= 1'b0;
            tx_active_reg   <= 1'b0;
            rx_rd_ptr_reg   <= '0;
            rx_wr_ptr_reg   <= '0;
            go_reg          <= 1'b0;
            acc_reg         <= 1'b0;
            tx_from_ram_reg <= 1'b0;
            rx_pop_reg      <= 1'b0;
        end else begin
            tx_rd_ptr_reg   <= tx_rd_ptr_next;
            tx_wr_ptr_reg   <= tx_wr_ptr_next;
            tx_full_reg     <= tx_full_next;
            tx_active_reg   <= tx_active_next;
            rx_rd_ptr_reg   <= rx_rd_ptr_next;
            rx_wr_ptr_reg   <= rx_wr_ptr_next;
            go_reg          <= go_next;
            acc_reg         <= acc_next;
            tx_from_ram_reg <= tx_from_ram_next;
            rx_pop_reg      <= rx_pop_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            byte_reg <= in_byte;
        end
    end

    // result assembly, the flags already hold the post-step values
    assign tx_byte_out   = !go_reg ? 8'd0 : (tx_from_ram_reg ? tx_rd_data_reg : byte_reg);
    assign read_byte_out = rx_pop_reg ? rx_rd_data_reg : 8'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= OUT_W'({rx_level, tx_active_reg, tx_full_reg, read_byte_out,
                                    acc_reg, tx_byte_out, go_reg});
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

    `UTRB_ASSERT_IMPL(a_tx_full_busy, aclk, aresetn, tx_full_reg,
                      tx_active_reg && (tx_wr_ptr_reg == tx_rd_ptr_reg))
    `UTRB_ASSERT_IMPL(a_rx_level_bound, aclk, aresetn, 1'b1,
                      rx_diff <= (RXP_W + 1)'(RX_DEPTH))
    `UTRB_ASSERT_NEXT(a_load_shows, aclk, aresetn, cmd.load_out,
                      m_tvalid && (m_tdata == $past(OUT_W'({rx_level, tx_active_reg,
                      tx_full_reg, read_byte_out, acc_reg, tx_byte_out, go_reg}))))

endmodule

/* src/uart_tx_rx_ring_buffers.sv */
// uart transmit/receive ring buffers, one command item at a time
// the accept registers the step flags; the load state then fills the output register
// one item at a time: accept state, then load state, before the next item is taken
// a result waiting on m_tready holds the next item's load stage, not its accept
// reset: synchronous active-low aresetn clears pointers, flags and the output valid
module uart_tx_rx_ring_buffers
    import utrb_pkg::*;
#(
    parameter int TX_DEPTH = 32,
    parameter int RX_DEPTH = 32,
    parameter int LVL_W    = $clog2(RX_DEPTH + 1),
    parameter int OUT_W    = ((OUT_FIXED_W + LVL_W + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    // command item channel
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] data_byte
    input  logic [1:0]       s_tuser,   // [1:0] cmd
    // result item channel
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // tx_go, tx_byte, accepted, read_byte,
                                        // tx_queue_full, tx_busy, rx_level, zero fill
);

    // command and status between the sequencer and the ring datapath
    utrb_cmd_t    ctrl_cmd;
    utrb_status_t dp_status;

    // two-state sequencer: accept an item, then load its result
    utrb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    // both rings, their pointers and flags, and the output register
    utrb_dp #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH),
        .LVL_W    (LVL_W),
        .OUT_W    (OUT_W)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (ctrl_cmd),
        .status   (dp_status),
        .in_cmd   (s_tuser),
        .in_byte  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
